[sv/sbm_pkg.sv]
// Shared types, codes and sizing constants for the sentence boundary marker tracker.
// Used by sbm_front, sbm_queue, sbm_back and the top level; depends on nothing.
package sbm_pkg;

    // sizing
    localparam int STACK_DEPTH    = 16;
    localparam int MAX_PAIRS      = 63;
    localparam int LONG_THRESHOLD = 1000;
    localparam int STACK_AW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W        = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W          = DEPTH_W + 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W         = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int ID_W    = 6;
    localparam int CODE_W  = ID_W + 1;
    localparam int COUNT_W = 16;
    localparam int SENT_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 1;

    // command codes
    localparam logic CMD_TOKEN = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // marker kinds
    localparam logic [1:0] MK_NONE  = 2'd0;
    localparam logic [1:0] MK_OPEN  = 2'd1;
    localparam logic [1:0] MK_CLOSE = 2'd2;
    localparam logic [1:0] MK_SYM   = 2'd3;

    // ender kinds
    localparam logic [1:0] EN_NONE    = 2'd0;
    localparam logic [1:0] EN_SURE    = 2'd1;
    localparam logic [1:0] EN_CONTEXT = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_HELD    = 2'd0;
    localparam logic [1:0] OUT_END     = 2'd1;
    localparam logic [1:0] OUT_FLUSHED = 2'd2;
    localparam logic [1:0] OUT_NOTHING = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ALLOW     = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_WORDS = 1'd1;

    // classified item passed from front to back
    typedef struct packed {
        logic              is_flush;
        logic              mk_valid;
        logic              may_pop;
        logic              may_push;
        logic [CODE_W-1:0] code;
        logic              ends;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic               allow;
        logic [COUNT_W-1:0] max_words;
    } t_cfg;

    // fold a sum of two stack positions back into the circular buffer
    function automatic logic [STACK_AW-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(STACK_DEPTH)) ? (s - SUM_W'(STACK_DEPTH)) : s;
        return r[STACK_AW-1:0];
    endfunction

endpackage

[sv/sbm_front.sv]
// Front end: classifies an incoming transaction into the compact item the back end executes.
// Depends on sbm_pkg.
module sbm_front
    import sbm_pkg::*;
(
    input  logic            i_cmd,
    input  logic [1:0]      i_marker_kind,
    input  logic [ID_W-1:0] i_marker_id,
    input  logic [1:0]      i_ender_kind,
    input  logic            i_next_starts_sentence,
    input  logic            i_last_in_batch,
    output t_item           o_item
);

    always_comb begin
        o_item.is_flush = (i_cmd == CMD_FLUSH);
        o_item.mk_valid = (i_marker_kind != MK_NONE) && (int'(i_marker_id) <= MAX_PAIRS);
        o_item.may_pop  = (i_marker_kind inside {MK_CLOSE, MK_SYM});
        o_item.may_push = (i_marker_kind inside {MK_OPEN, MK_SYM});
        o_item.code     = {(i_marker_kind == MK_SYM), i_marker_id};
        case (i_ender_kind)
            EN_SURE:    o_item.ends = 1'b1;
            EN_CONTEXT: o_item.ends = i_last_in_batch | i_next_starts_sentence;
            default:    o_item.ends = 1'b0; // not an ender, or unknown code
        endcase
    end

endmodule

[sv/sbm_queue.sv]
// Short FIFO of classified items between front and back end.
// Depends on sbm_pkg.
module sbm_queue
    import sbm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_W'(QUEUE_DEPTH));

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("queue fill did not follow a lone push");

endmodule

[sv/sbm_back.sv]
// Back end: marker stack, no-split counter, sentence counter and the output register.
// Depends on sbm_pkg.
module sbm_back
    import sbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_qstat             i_qstat,
    input  t_item              i_item,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_outcome,
    output logic [SENT_W-1:0]  o_sentence_number,
    output logic               o_long_warning,
    output logic [DEPTH_W-1:0] o_nesting_depth
);

    logic [CODE_W-1:0]   r_stack [STACK_DEPTH];
    logic [STACK_AW-1:0] r_base;
    logic [DEPTH_W-1:0]  r_depth;
    logic [COUNT_W-1:0]  r_count;
    logic                r_pending;
    logic [SENT_W-1:0]   r_sent;

    logic [STACK_AW-1:0] n_base;
    logic [DEPTH_W-1:0]  n_depth;
    logic [COUNT_W-1:0]  n_count;
    logic                n_pending;
    logic [SENT_W-1:0]   n_sent;
    logic [1:0]          n_outcome;
    logic                n_warn;

    logic                r_out_valid;
    logic [1:0]          r_outcome;
    logic [SENT_W-1:0]   r_number;
    logic                r_warn;
    logic [DEPTH_W-1:0]  r_out_depth;

    logic [STACK_AW-1:0] top_idx;
    logic [STACK_AW-1:0] wr_idx;
    logic [CODE_W-1:0]   top_code;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                top_hit;
    logic                tracking;
    logic                do_push;
    logic                check;

    assign o_pop    = !i_qstat.empty && (!r_out_valid || !i_out_stall);
    assign tracking = !i_cfg.allow;
    assign top_idx  = wrap_idx(SUM_W'(r_base) + SUM_W'(r_depth) - SUM_W'(1));
    assign wr_idx   = (r_depth == DEPTH_W'(STACK_DEPTH)) ? r_base
                    : wrap_idx(SUM_W'(r_base) + SUM_W'(r_depth));
    assign top_code = r_stack[top_idx];
    assign cnt_inc  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign top_hit  = i_item.mk_valid && (r_depth != '0) && i_item.may_pop
                    && (top_code == i_item.code);

    always_comb begin
        n_base    = r_base;
        n_depth   = r_depth;
        n_count   = r_count;
        n_pending = r_pending;
        n_sent    = r_sent;
        n_outcome = OUT_HELD;
        n_warn    = 1'b0;
        do_push   = 1'b0;
        check     = 1'b1;
        if (i_item.is_flush) begin
            if (r_pending) begin
                n_sent    = r_sent + 1'b1;
                n_depth   = '0;
                n_count   = '0;
                n_pending = 1'b0;
                n_outcome = OUT_FLUSHED;
            end else begin
                n_outcome = OUT_NOTHING;
            end
        end else begin
            if (tracking && top_hit) begin
                n_depth = r_depth - 1'b1;
                n_count = (r_depth == DEPTH_W'(1)) ? '0 : cnt_inc;
                check   = 1'b0;
            end else if (tracking && i_item.mk_valid && i_item.may_push) begin
                // full stack: the oldest entry is overwritten and the base moves up
                do_push = 1'b1;
                if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                    n_base = (int'(r_base) == STACK_DEPTH - 1) ? '0 : r_base + 1'b1;
                end else begin
                    n_depth = r_depth + 1'b1;
                end
                n_count = cnt_inc;
                check   = 1'b0;
            end else if (r_depth != '0) begin
                n_count = cnt_inc;
                if ((i_cfg.max_words == '0) || (cnt_inc <= i_cfg.max_words)) begin
                    check = 1'b0;
                end
                n_warn = (cnt_inc == COUNT_W'(LONG_THRESHOLD));
            end
            n_pending = 1'b1;
            if (check && i_item.ends) begin
                n_sent    = r_sent + 1'b1;
                n_depth   = '0;
                n_count   = '0;
                n_pending = 1'b0;
                n_outcome = OUT_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_depth     <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_base    <= n_base;
                r_depth   <= n_depth;
                r_count   <= n_count;
                r_pending <= n_pending;
                r_sent    <= n_sent;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_outcome   <= n_outcome;
            r_number    <= n_sent;
            r_warn      <= n_warn;
            r_out_depth <= n_depth;
        end
        if (o_pop && do_push) begin
            r_stack[wr_idx] <= i_item.code;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_outcome;
    assign o_sentence_number = r_number;
    assign o_long_warning    = r_warn;
    assign o_nesting_depth   = r_out_depth;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("marker stack depth beyond capacity");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (r_depth == '0))
        else $error("open markers with no words pending");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth == '0) |-> (r_count == '0))
        else $error("no-split count left over with empty stack");

endmodule

[sv/sentence_boundary_marker_tracker.sv]
// Top level of the sentence boundary marker tracker: configuration registers and wiring.
// Depends on sbm_pkg, sbm_front, sbm_queue and sbm_back.
//
// Takes one pre-classified token or flush command per transaction and returns exactly one
// result per transaction, in order. Throughput is one transaction per clock while the
// output is not stalled. A result passes through the item queue into the back end's
// output register, where it is held until taken. The rate is set by the back end, which
// reads the top of the marker stack, updates stack depth and counters and registers the
// result. A two-entry queue sits between the classifier and the back end, so the input
// keeps flowing while a finished result waits on a stalled output; o_in_stall rises only
// once that queue is full. The marker stack is a circular buffer of STACK_DEPTH
// entries: a push onto a full stack overwrites the oldest entry. Configuration
// (allow_between_markers at index 0, max_words at index 1) is written through
// i_cfg_we/i_cfg_index/i_cfg_data and must only change while no transaction is in flight.
// Reset is synchronous and active low; no clearing pass is needed afterwards.
module sentence_boundary_marker_tracker
    import sbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [1:0]         i_marker_kind,
    input  logic [ID_W-1:0]    i_marker_id,
    input  logic [1:0]         i_ender_kind,
    input  logic               i_next_starts_sentence,
    input  logic               i_last_in_batch,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_outcome,
    output logic [SENT_W-1:0]  o_sentence_number,
    output logic               o_long_warning,
    output logic [DEPTH_W-1:0] o_nesting_depth
);

    t_cfg   r_cfg;
    t_item  front_item;
    t_item  q_item;
    t_qstat q_stat;
    logic   q_push;
    logic   q_pop;

    // configuration registers; allow_between_markers resets to 1 (tracking off)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.allow     <= 1'b1;
            r_cfg.max_words <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALLOW:     r_cfg.allow     <= i_cfg_data[0];
                CFG_MAX_WORDS: r_cfg.max_words <= i_cfg_data[COUNT_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // input transaction is taken whenever the queue has room
    assign o_in_stall = q_stat.full;
    assign q_push     = i_in_valid && !q_stat.full;

    sbm_front u_front (
        .i_cmd                  (i_cmd),
        .i_marker_kind          (i_marker_kind),
        .i_marker_id            (i_marker_id),
        .i_ender_kind           (i_ender_kind),
        .i_next_starts_sentence (i_next_starts_sentence),
        .i_last_in_batch        (i_last_in_batch),
        .o_item                 (front_item)
    );

    sbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    sbm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_qstat           (q_stat),
        .i_item            (q_item),
        .o_pop             (q_pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_outcome         (o_outcome),
        .o_sentence_number (o_sentence_number),
        .o_long_warning    (o_long_warning),
        .o_nesting_depth   (o_nesting_depth)
    );

endmodule
